// ===== rtl/lis_pkg.sv =====
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants and types for the longest increasing subsequence tracker.
// ----------------------------------------------------------------------------
package lis_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_ITEMS   = 65536;
    localparam int VALUE_WIDTH = 32;

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W   = 16;
    localparam int ENTRY_W = VALUE_WIDTH + IDX_W;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [SLOT_W-1:0]             slot_t;
    typedef logic [LEN_W-1:0]              len_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [ENTRY_W-1:0]            entry_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_SEARCH = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

endpackage

// ===== rtl/lis_ram.sv =====
// ----------------------------------------------------------------------------
// lis_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/longest_increasing_subsequence_tracker_top.sv =====
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_tracker_top
// Patience-method tail table with a binary search over a single-port RAM.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | value, start_req
//   out     | out_valid/out_ready| item_index, slot, has_predecessor,
//           |                    | predecessor_index, lis_length, discarded,
//           |                    | overflow
//
// A request moves from idle to decide, through search when a binary search
// is needed, and on to done; the search reads the single RAM port once per
// step over a table of 1024 entries. The first and last tails sit in
// registers, so the search touches the RAM only at midpoints. A request can
// be taken while the previous result still waits in the output register; a
// stalled output holds the finished request in its last state. Reset clears
// the length and the item count and needs no pass over the RAM.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_tracker_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lis_pkg::value_t        value,
    input  logic                   start_req,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lis_pkg::idx_t          item_index,
    output lis_pkg::slot_t         slot,
    output logic                   has_predecessor,
    output lis_pkg::idx_t          predecessor_index,
    output lis_pkg::len_t          lis_length,
    output logic                   discarded,
    output logic                   overflow
);

    import lis_pkg::*;

    state_t state_reg, state_next;
    len_t   len_reg, len_next;
    cnt_t   cnt_reg, cnt_next;
    logic   out_valid_reg, out_valid_next;

    value_t v_reg, v_next;
    logic   start_reg, start_next;
    value_t first_val_reg, first_val_next;
    idx_t   first_idx_reg, first_idx_next;
    value_t last_val_reg, last_val_next;
    idx_t   last_idx_reg, last_idx_next;

    slot_t  lo_reg, lo_next;
    slot_t  hi_reg, hi_next;
    slot_t  mid_reg, mid_next;
    idx_t   pred_reg, pred_next;
    idx_t   idx_reg, idx_next;
    logic   wr_reg, wr_next;
    logic   hasp_reg, hasp_next;
    logic   disc_reg, disc_next;
    logic   ovf_reg, ovf_next;
    len_t   newlen_reg, newlen_next;
    cnt_t   newcnt_reg, newcnt_next;

    idx_t   o_index_reg, o_index_next;
    slot_t  o_slot_reg, o_slot_next;
    logic   o_hasp_reg, o_hasp_next;
    idx_t   o_pred_reg, o_pred_next;
    len_t   o_len_reg, o_len_next;
    logic   o_disc_reg, o_disc_next;
    logic   o_ovf_reg, o_ovf_next;

    logic   ram_we;
    slot_t  ram_addr;
    entry_t ram_wdata;
    entry_t ram_rdata;

    value_t rd_val;
    idx_t   rd_idx;
    logic   rd_less;
    slot_t  step_lo, step_hi, step_mid;
    idx_t   step_pred;
    slot_t  init_hi, init_mid;
    cnt_t   cur;
    logic   commit;

    lis_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_tail_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign rd_val  = value_t'(ram_rdata[ENTRY_W-1:IDX_W]);
    assign rd_idx  = ram_rdata[IDX_W-1:0];
    assign rd_less = rd_val < v_reg;

    // One binary search step on the entry that arrived this cycle.
    always_comb
    begin
        step_lo   = lo_reg;
        step_hi   = hi_reg;
        step_pred = pred_reg;
        if (rd_less)
        begin
            step_lo   = mid_reg + slot_t'(1);
            step_pred = rd_idx;
        end
        else
        begin
            step_hi = mid_reg;
        end
        step_mid = step_lo + ((step_hi - step_lo) >> 1);
    end

    assign init_hi  = slot_t'(len_reg - len_t'(1));
    assign init_mid = slot_t'(1) + ((init_hi - slot_t'(1)) >> 1);
    assign cur      = start_reg ? '0 : cnt_reg;
    assign commit   = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (state_reg)
            S_DECIDE: ram_addr = init_mid;
            S_SEARCH: ram_addr = step_mid;
            S_DONE:   ram_addr = lo_reg;
            default:  ram_addr = mid_reg;
        endcase
    end

    assign ram_we    = (state_reg == S_DONE) && commit && wr_reg;
    assign ram_wdata = {v_reg, idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        v_next         = v_reg;
        start_next     = start_reg;
        first_val_next = first_val_reg;
        first_idx_next = first_idx_reg;
        last_val_next  = last_val_reg;
        last_idx_next  = last_idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pred_next      = pred_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        hasp_next      = hasp_reg;
        disc_next      = disc_reg;
        ovf_next       = ovf_reg;
        newlen_next    = newlen_reg;
        newcnt_next    = newcnt_reg;
        o_index_next   = o_index_reg;
        o_slot_next    = o_slot_reg;
        o_hasp_next    = o_hasp_reg;
        o_pred_next    = o_pred_reg;
        o_len_next     = o_len_reg;
        o_disc_next    = o_disc_reg;
        o_ovf_next     = o_ovf_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = value;
                    start_next = start_req;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                idx_next    = idx_t'(cur);
                lo_next     = '0;
                pred_next   = '0;
                wr_next     = 1'b0;
                hasp_next   = 1'b0;
                disc_next   = 1'b0;
                ovf_next    = 1'b0;
                newlen_next = len_reg;
                newcnt_next = cnt_reg + cnt_t'(1);
                state_next  = S_DONE;
                if (start_reg || len_reg == '0)
                begin
                    wr_next     = 1'b1;
                    newlen_next = len_t'(1);
                    newcnt_next = cur + cnt_t'(1);
                end
                else if (cnt_reg >= cnt_t'(MAX_ITEMS))
                begin
                    ovf_next    = 1'b1;
                    newcnt_next = cnt_reg;
                end
                else if (v_reg > last_val_reg)
                begin
                    if (len_reg >= len_t'(TABLE_DEPTH))
                    begin
                        ovf_next    = 1'b1;
                        newcnt_next = cnt_reg;
                    end
                    else
                    begin
                        wr_next     = 1'b1;
                        hasp_next   = 1'b1;
                        lo_next     = slot_t'(len_reg);
                        pred_next   = last_idx_reg;
                        newlen_next = len_reg + len_t'(1);
                    end
                end
                else if (v_reg == last_val_reg)
                begin
                    disc_next = 1'b1;
                end
                else if (v_reg <= first_val_reg)
                begin
                    wr_next = 1'b1;
                end
                else
                begin
                    // The answer lies in slots 1 .. length-1; the predecessor
                    // defaults to slot 0 until a smaller midpoint is seen.
                    wr_next   = 1'b1;
                    hasp_next = 1'b1;
                    lo_next   = slot_t'(1);
                    hi_next   = init_hi;
                    pred_next = first_idx_reg;
                    if (slot_t'(1) < init_hi)
                    begin
                        mid_next   = init_mid;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                lo_next   = step_lo;
                hi_next   = step_hi;
                mid_next  = step_mid;
                pred_next = step_pred;
                if (!(step_lo < step_hi))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    o_index_next   = idx_reg;
                    o_slot_next    = lo_reg;
                    o_hasp_next    = hasp_reg;
                    o_pred_next    = pred_reg;
                    o_len_next     = newlen_reg;
                    o_disc_next    = disc_reg;
                    o_ovf_next     = ovf_reg;
                    len_next       = newlen_reg;
                    cnt_next       = newcnt_reg;
                    if (wr_reg && lo_reg == '0)
                    begin
                        first_val_next = v_reg;
                        first_idx_next = idx_reg;
                    end
                    if (wr_reg && len_t'(lo_reg) == newlen_reg - len_t'(1))
                    begin
                        last_val_next = v_reg;
                        last_idx_next = idx_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        start_reg     <= start_next;
        first_val_reg <= first_val_next;
        first_idx_reg <= first_idx_next;
        last_val_reg  <= last_val_next;
        last_idx_reg  <= last_idx_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pred_reg      <= pred_next;
        idx_reg       <= idx_next;
        wr_reg        <= wr_next;
        hasp_reg      <= hasp_next;
        disc_reg      <= disc_next;
        ovf_reg       <= ovf_next;
        newlen_reg    <= newlen_next;
        newcnt_reg    <= newcnt_next;
        o_index_reg   <= o_index_next;
        o_slot_reg    <= o_slot_next;
        o_hasp_reg    <= o_hasp_next;
        o_pred_reg    <= o_pred_next;
        o_len_reg     <= o_len_next;
        o_disc_reg    <= o_disc_next;
        o_ovf_reg     <= o_ovf_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign item_index        = o_index_reg;
    assign slot              = o_slot_reg;
    assign has_predecessor   = o_hasp_reg;
    assign predecessor_index = o_pred_reg;
    assign lis_length        = o_len_reg;
    assign discarded         = o_disc_reg;
    assign overflow          = o_ovf_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= len_t'(TABLE_DEPTH))
        else $error("table length beyond depth");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> (mid_reg >= lo_reg) && (mid_reg < hi_reg))
        else $error("search midpoint outside its window");

    a_pred_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_hasp_reg |-> o_slot_reg != '0 && !o_disc_reg && !o_ovf_reg)
        else $error("predecessor reported for slot zero or a dropped request");

    a_overflow_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ovf_reg && !disc_reg)
        else $error("table written by an overflow or discarded request");

    a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !commit |=> $stable(o_index_reg) && out_valid_reg)
        else $error("pending result overwritten");

endmodule
